@@ rtl/core/pidc_pkg.sv @@
package pidc_pkg;

	// field and register widths
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned DT_W       = 31;
	localparam int unsigned ERR_W      = DATA_W + 1;
	localparam int unsigned DIFF_W     = ERR_W + 1;
	localparam int unsigned INTEG_W    = 48;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_UPPER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LOWER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd5;

	// register reset values
	localparam logic [DT_W-1:0]          DT_RESET    = 31'd65536;
	localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'sh8000_0000;

	// divider request and response
	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] diff;
	} div_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [INTEG_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ rtl/core/pidc_in_if.sv @@
interface pidc_in_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] target;
	logic signed [DATA_W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

@@ rtl/core/pidc_out_if.sv @@
interface pidc_out_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

@@ rtl/core/pid_controller_clamped_top.sv @@
// Channel     Dir  Payload                 Transfer
// sample_ch   in   target, measured        valid && ready
// drive_ch    out  drive                   valid && ready
// cfg_*       in   cfg_idx, cfg_data       cfg_we
//
// Drive valid rises once the radix-4 derivative divider (load, run, saturate)
// is done and the derivative product and clamp step have run, with the first
// three products on the shared 33x25 multiplier running alongside the divider.
// A new sample is taken whenever the sequencer is idle, never mid-computation.
// An unsent drive value holds the sequencer at the clamp step.
// Reset (arst_n low) restores the register defaults, clears error and integral.
module pid_controller_clamped_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
	pidc_in_if.sink                           sample_ch,
	pidc_out_if.source                        drive_ch
);
	import pidc_pkg::*;

	localparam int unsigned HALF_W  = INTEG_W / 2;
	localparam int unsigned MA_W    = ERR_W;
	localparam int unsigned MB_W    = HALF_W + 1;
	localparam int unsigned PROD_W  = MA_W + MB_W;
	localparam int unsigned TERM_W  = MA_W + INTEG_W + 1;
	localparam int unsigned ACC_W   = 2 * DATA_W + 3;
	localparam int unsigned ISUM_W  = INTEG_W + 2;
	localparam logic signed [ISUM_W-1:0] ISAT_HI = (ISUM_W'(1) <<< (INTEG_W - 1)) - ISUM_W'(1);
	localparam logic signed [ISUM_W-1:0] ISAT_LO = -(ISUM_W'(1) <<< (INTEG_W - 1));

	typedef enum logic [1:0] {P_INTEG, P_PROP, P_IGAIN, P_DERIV} prod_t;
	typedef enum logic [2:0] {S_IDLE, S_MLO, S_MHI, S_MACC, S_MFOLD, S_CLAMP} state_t;

	// configuration registers
	logic [DT_W-1:0]          dt_q;
	logic signed [DATA_W-1:0] upper_q, lower_q, kp_q, kd_q, ki_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q    <= DT_RESET;
			upper_q <= UPPER_RESET;
			lower_q <= LOWER_RESET;
			kp_q    <= '0;
			kd_q    <= '0;
			ki_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SAMPLE_PERIOD: dt_q    <= cfg_data[DT_W-1:0];
				CFG_OUTPUT_UPPER:  upper_q <= cfg_data;
				CFG_OUTPUT_LOWER:  lower_q <= cfg_data;
				CFG_GAIN_PROP:     kp_q    <= cfg_data;
				CFG_GAIN_DERIV:    kd_q    <= cfg_data;
				CFG_GAIN_INTEG:    ki_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t                    state_q;
	prod_t                     p_q;
	logic signed [ERR_W-1:0]   e_q, last_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [PROD_W-1:0]  prod_s1, lo_q;
	logic signed [TERM_W-1:0]  term_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DATA_W-1:0]  drive_q;
	logic                      ovld_q;

	logic                      in_xfer;
	logic                      out_xfer;
	logic                      clamp_go;
	logic signed [ERR_W-1:0]   e_new;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [INTEG_W-1:0] mul_v;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ISUM_W-1:0]  isum;
	logic signed [ISUM_W-1:0]  isat;

	assign sample_ch.ready = (state_q == S_IDLE);
	assign in_xfer         = sample_ch.valid && sample_ch.ready;
	assign out_xfer        = drive_ch.valid && drive_ch.ready;
	assign e_new           = ERR_W'(sample_ch.target) - ERR_W'(sample_ch.measured);

	// clamp step loads the drive register once it is free
	assign clamp_go = (state_q == S_CLAMP) && (!ovld_q || out_xfer);

	// derivative divider runs alongside the first three products
	assign div_req.start = in_xfer;
	assign div_req.diff  = DIFF_W'(e_new) - DIFF_W'(last_err_q);

	pidc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (dt_q),
		.rsp     (div_rsp)
	);

	// shared multiplier operand select
	always_comb begin
		case (p_q)
			P_INTEG: begin
				mul_a = signed'({2'b00, dt_q});
				mul_v = INTEG_W'(e_q);
			end
			P_PROP: begin
				mul_a = MA_W'(kp_q);
				mul_v = INTEG_W'(e_q);
			end
			P_IGAIN: begin
				mul_a = MA_W'(ki_q);
				mul_v = integ_q;
			end
			P_DERIV: begin
				mul_a = MA_W'(kd_q);
				mul_v = div_rsp.quot;
			end
			default: begin
				mul_a = '0;
				mul_v = '0;
			end
		endcase
		if (state_q == S_MHI) begin
			mul_b = signed'({mul_v[INTEG_W-1], mul_v[INTEG_W-1:HALF_W]});
		end else begin
			mul_b = signed'({1'b0, mul_v[HALF_W-1:0]});
		end
		prod = mul_a * mul_b;
	end

	// integral update with saturation
	always_comb begin
		isum = ISUM_W'(integ_q) + ISUM_W'(term_q >>> FRAC_W);
		if (isum > ISAT_HI) begin
			isat = ISAT_HI;
		end else if (isum < ISAT_LO) begin
			isat = ISAT_LO;
		end else begin
			isat = isum;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			p_q        <= P_INTEG;
			e_q        <= '0;
			last_err_q <= '0;
			integ_q    <= '0;
			prod_s1    <= '0;
			lo_q       <= '0;
			term_q     <= '0;
			acc_q      <= '0;
			drive_q    <= '0;
			ovld_q     <= 1'b0;
		end else begin
			if (clamp_go) begin
				ovld_q <= 1'b1;
			end else if (out_xfer) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						e_q        <= e_new;
						last_err_q <= e_new;
						p_q        <= P_INTEG;
						acc_q      <= '0;
						state_q    <= S_MLO;
					end
				end
				S_MLO: begin
					// derivative product waits for the divider
					if (p_q != P_DERIV || div_rsp.done) begin
						prod_s1 <= prod;
						state_q <= S_MHI;
					end
				end
				S_MHI: begin
					lo_q    <= prod_s1;
					prod_s1 <= prod;
					state_q <= S_MACC;
				end
				S_MACC: begin
					term_q  <= TERM_W'(lo_q) + (TERM_W'(prod_s1) <<< HALF_W);
					state_q <= S_MFOLD;
				end
				S_MFOLD: begin
					if (p_q == P_INTEG) begin
						integ_q <= INTEG_W'(isat);
					end else begin
						acc_q <= acc_q + ACC_W'(term_q >>> FRAC_W);
					end
					if (p_q == P_DERIV) begin
						state_q <= S_CLAMP;
					end else begin
						p_q     <= prod_t'(p_q + 2'd1);
						state_q <= S_MLO;
					end
				end
				S_CLAMP: begin
					if (clamp_go) begin
						if (acc_q > ACC_W'(upper_q)) begin
							drive_q <= upper_q;
						end else if (acc_q < ACC_W'(lower_q)) begin
							drive_q <= lower_q;
						end else begin
							drive_q <= DATA_W'(acc_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign drive_ch.valid = ovld_q;
	assign drive_ch.drive = drive_q;

endmodule

@@ rtl/core/pidc_div.sv @@
module pidc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pidc_pkg::div_req_t         req,
	input  logic [pidc_pkg::DT_W-1:0]  divisor,
	output pidc_pkg::div_rsp_t         rsp
);
	import pidc_pkg::*;

	localparam int unsigned NUM_W  = DIFF_W + FRAC_W;
	localparam int unsigned ITER   = NUM_W / 2;
	localparam int unsigned CNT_W  = $clog2(ITER);
	localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (INTEG_W - 1);
	localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);

	typedef enum logic [1:0] {D_IDLE, D_LOAD, D_RUN, D_SAT} dstate_t;

	dstate_t                   state_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic                      neg_q;
	logic [NUM_W-1:0]          num_q;
	logic [DT_W-1:0]           rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic signed [INTEG_W-1:0] quot_q;

	logic [DIFF_W-1:0] mag;
	logic [DT_W:0]     r1s, r2s;
	logic [DT_W-1:0]   r1, r2;
	logic              ge1, ge2;
	logic [NUM_W-1:0]  qlim;

	// magnitude of the error difference
	assign mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

	// two restoring steps per cycle
	always_comb begin
		r1s = {rem_q, num_q[NUM_W-1]};
		ge1 = r1s >= {1'b0, divisor};
		r1  = ge1 ? DT_W'(r1s - {1'b0, divisor}) : DT_W'(r1s);
		r2s = {r1, num_q[NUM_W-2]};
		ge2 = r2s >= {1'b0, divisor};
		r2  = ge2 ? DT_W'(r2s - {1'b0, divisor}) : DT_W'(r2s);
	end

	// saturation limit depends on sign
	always_comb begin
		if (neg_q) begin
			qlim = (num_q > NEG_LIM) ? NEG_LIM : num_q;
		end else begin
			qlim = (num_q > POS_LIM) ? POS_LIM : num_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			diff_q  <= '0;
			neg_q   <= 1'b0;
			num_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			quot_q  <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						diff_q <= req.diff;
						if (divisor == '0) begin
							// zero period: derivative is zero
							quot_q <= '0;
							done_q <= 1'b1;
						end else begin
							done_q  <= 1'b0;
							state_q <= D_LOAD;
						end
					end
				end
				D_LOAD: begin
					num_q   <= {mag, {FRAC_W{1'b0}}};
					neg_q   <= diff_q[DIFF_W-1];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					rem_q <= r2;
					num_q <= {num_q[NUM_W-3:0], ge1, ge2};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ITER - 1)) begin
						state_q <= D_SAT;
					end
				end
				D_SAT: begin
					quot_q  <= neg_q ? INTEG_W'(NUM_W'(0) - qlim) : INTEG_W'(qlim);
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ test/pid_controller_clamped_top_tb.sv @@
module pid_controller_clamped_top_tb;
	import pidc_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		logic signed [DATA_W-1:0] tgt;
		logic signed [DATA_W-1:0] meas;
		logic                     typed;
		logic signed [DATA_W-1:0] want;
	} step_t;

	// per accepted sample: a typed-in drive value, if the row carries one
	typedef struct packed {
		logic                     typed;
		logic signed [DATA_W-1:0] want;
	} sample_note_t;

	// indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] NEG_MAX = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_M_ONE = 32'shFFFF_0000;
	localparam logic signed [DATA_W-1:0] ZERO    = 32'sd0;

	localparam wide_t INTEG_MAX = 128'sh7FFF_FFFF_FFFF;
	localparam wide_t INTEG_MIN = ~INTEG_MAX;

	localparam int NPLAN       = 36;
	localparam int NPHASE      = 9;
	localparam int PHASE_ITEMS = 110;
	localparam int STUCK_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	// directed rows: after-reset zeros, clamp extremes, crossed limits,
	// zero period, masked period bit, spare indexes, extreme gains
	localparam step_t PLAN [NPLAN] = '{
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, POS_MAX, NEG_MAX, 1'b1, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, POS_MAX, 1'b1, ZERO},
		'{ROW_WRITE, CFG_GAIN_PROP, Q_ONE, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, POS_MAX, NEG_MAX, 1'b1, POS_MAX},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, POS_MAX, 1'b1, NEG_MAX},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, 32'sh0005_0000, 32'sh0002_0000, 1'b1,
			32'sh0003_0000},
		'{ROW_WRITE, CFG_OUTPUT_UPPER, Q_M_ONE, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_OUTPUT_LOWER, Q_ONE, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, ZERO, ZERO, 1'b1, Q_M_ONE},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, ZERO, 32'sh000A_0000, 1'b1, Q_ONE},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, 32'sh0002_0000, ZERO, 1'b1, Q_M_ONE},
		'{ROW_WRITE, CFG_OUTPUT_UPPER, POS_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_OUTPUT_LOWER, NEG_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 32'h0, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_INTEG, Q_ONE, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_DERIV, Q_ONE, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, 32'sh0007_8000, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, 32'sh1234_5678, 1'b0, ZERO},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 32'h8000_0001, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, POS_MAX, NEG_MAX, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, POS_MAX, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, 32'sd1, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_SPARE_LO, 32'hFFFF_FFFF, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_SPARE_HI, 32'h0, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, Q_ONE, 32'sh0000_8000, 1'b0, ZERO},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 32'h7FFF_FFFF, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_PROP, NEG_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_INTEG, POS_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_DERIV, NEG_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, POS_MAX, NEG_MAX, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, POS_MAX, NEG_MAX, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, POS_MAX, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, -32'sd1, 32'sd1, 1'b0, ZERO},
		'{ROW_WRITE, CFG_GAIN_DERIV, POS_MAX, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, ZERO, ZERO, 1'b0, ZERO},
		'{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 32'h0, NEG_MAX, ZERO, 1'b0, ZERO}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	pidc_in_if  sample_ch ();
	pidc_out_if drive_ch ();

	pid_controller_clamped_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.drive_ch  (drive_ch)
	);

	always #2 clk = ~clk;

	// register mirror and controller state, as after reset
	logic [DT_W-1:0]           period_r = DT_RESET;
	logic signed [DATA_W-1:0]  upper_r  = UPPER_RESET;
	logic signed [DATA_W-1:0]  lower_r  = LOWER_RESET;
	logic signed [DATA_W-1:0]  kp_r     = '0;
	logic signed [DATA_W-1:0]  kd_r     = '0;
	logic signed [DATA_W-1:0]  ki_r     = '0;
	logic signed [ERR_W-1:0]   prev_err  = '0;
	logic signed [INTEG_W-1:0] integ_acc = '0;

	logic signed [DATA_W-1:0] pending_drive [$];
	sample_note_t             sample_notes [$];

	logic calm = 1'b0;
	int   src_pct = 30;
	int   sink_pct = 30;
	int   mismatches = 0;
	int   stuck_cycles = 0;
	int   stall_left = 0;

	// one PID step: advances error and integral, returns the clamped drive
	function automatic logic signed [DATA_W-1:0] next_drive(
		input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas
	);
		wide_t err, dt, integ, mag, quo, deriv, total;
		err = wide_t'(tgt) - wide_t'(meas);
		dt = wide_t'({1'b0, period_r});

		// integral gets floor(e*dt) in Q16.16, saturated to 48 bits
		integ = wide_t'(integ_acc) + ((err * dt) >>> FRAC_W);
		if (integ > INTEG_MAX)
			integ = INTEG_MAX;
		else if (integ < INTEG_MIN)
			integ = INTEG_MIN;

		// derivative truncates toward zero; a zero period gives none
		deriv = '0;
		if (period_r != '0) begin
			deriv = err - wide_t'(prev_err);
			mag = deriv[127] ? -deriv : deriv;
			quo = (mag <<< FRAC_W) / dt;
			if (deriv[127])
				deriv = (quo > INTEG_MAX) ? INTEG_MIN : -quo;
			else
				deriv = (quo > INTEG_MAX) ? INTEG_MAX : quo;
		end

		total = ((wide_t'(kp_r) * err) >>> FRAC_W)
			+ ((wide_t'(ki_r) * integ) >>> FRAC_W)
			+ ((wide_t'(kd_r) * deriv) >>> FRAC_W);

		prev_err = err[ERR_W-1:0];
		integ_acc = integ[INTEG_W-1:0];

		// upper is tested first, so crossed limits favor it
		if (total > wide_t'(upper_r))
			return upper_r;
		else if (total < wide_t'(lower_r))
			return lower_r;
		return total[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] corner_value();
		case ($urandom_range(0, 4))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return ZERO;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] scaled_rand(int lo_sh, int hi_sh);
		logic signed [DATA_W-1:0] v;
		v = $urandom;
		return v >>> $urandom_range(lo_sh, hi_sh);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return ZERO;
			1, 2: return scaled_rand(12, 16);
			3: return scaled_rand(0, 8);
			4: return $urandom;
			default: return corner_value();
		endcase
	endfunction

	// register write; the mirror follows, the enable stays high until a sample is sent
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			CFG_SAMPLE_PERIOD: period_r = data[DT_W-1:0];
			CFG_OUTPUT_UPPER:  upper_r = data;
			CFG_OUTPUT_LOWER:  lower_r = data;
			CFG_GAIN_PROP:     kp_r = data;
			CFG_GAIN_DERIV:    kd_r = data;
			CFG_GAIN_INTEG:    ki_r = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// present one sample and hold it until the transfer
	task automatic send_sample(
		input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas,
		input logic                     typed,
		input logic signed [DATA_W-1:0] want
	);
		cfg_we <= 1'b0;
		if (!calm && $urandom_range(0, 99) < src_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.target <= tgt;
		sample_ch.measured <= meas;
		sample_notes.push_back('{typed, want});
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	// idle until every expected drive has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_drive.size() != 0 || sample_notes.size() != 0) @(posedge clk);
	endtask

	task automatic random_setup();
		logic signed [DATA_W-1:0] a, b;
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);

		case ($urandom_range(0, 5))
			0: write_reg(CFG_SAMPLE_PERIOD, 32'h1);
			1: write_reg(CFG_SAMPLE_PERIOD, 32'h7FFF_FFFF);
			2: write_reg(CFG_SAMPLE_PERIOD, 32'h0);
			3: write_reg(CFG_SAMPLE_PERIOD, $urandom_range(1, 262144));
			default: write_reg(CFG_SAMPLE_PERIOD, $urandom);
		endcase

		a = scaled_rand(0, 12);
		b = scaled_rand(0, 12);
		case ($urandom_range(0, 4))
			0: begin
				a = UPPER_RESET;
				b = LOWER_RESET;
			end
			1, 2: begin
				if (a < b) begin
					a = b;
					b = scaled_rand(31, 31) < 0 ? a - b : b;
				end
			end
			3: begin
				// crossed: upper below lower
				if (a > b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
			default: b = a;
		endcase
		write_reg(CFG_OUTPUT_UPPER, a);
		write_reg(CFG_OUTPUT_LOWER, b);
		write_reg(CFG_GAIN_PROP, pick_gain());
		write_reg(CFG_GAIN_DERIV, pick_gain());
		write_reg(CFG_GAIN_INTEG, pick_gain());
	endtask

	task automatic random_sample();
		logic signed [DATA_W-1:0] t, m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// measurement tracking near the setpoint
				t = scaled_rand(0, 16);
				m = t + scaled_rand(6, 28);
			end
			4, 5, 6: begin
				t = $urandom;
				m = $urandom;
			end
			7: begin
				t = corner_value();
				m = corner_value();
			end
			default: begin
				t = scaled_rand(13, 13);
				m = scaled_rand(13, 13);
			end
		endcase
		send_sample(t, m, 1'b0, ZERO);
	endtask

	// sink side: ready with random stall bursts
	initial begin
		drive_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				drive_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
				drive_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				drive_ch.ready <= 1'b1;
			end
		end
	end

	// check drive transfers, predict on sample transfers, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (pending_drive.size() == 0) begin
					mismatches++;
					$error("drive: expected none, actual %0d", drive_ch.drive);
				end else if (drive_ch.drive !== pending_drive[0]) begin
					mismatches++;
					$error("drive: expected %0d, actual %0d", pending_drive[0], drive_ch.drive);
				end
				if (pending_drive.size() != 0)
					void'(pending_drive.pop_front());
			end
			if (sample_ch.valid && sample_ch.ready) begin
				if (sample_notes.size() != 0) begin
					if (sample_notes[0].typed) begin
						void'(next_drive(sample_ch.target, sample_ch.measured));
						pending_drive.push_back(sample_notes[0].want);
					end else begin
						pending_drive.push_back(next_drive(sample_ch.target, sample_ch.measured));
					end
					void'(sample_notes.pop_front());
				end
			end
			if ((drive_ch.valid && drive_ch.ready) || (sample_ch.valid && sample_ch.ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$error("watchdog: no transfer for %0d cycles", stuck_cycles);
				$display("pid_controller_clamped_top verification failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		sample_ch.valid <= 1'b0;
		sample_ch.target <= '0;
		sample_ch.measured <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NPLAN; r++) begin
			if (PLAN[r].kind == ROW_WRITE) begin
				drain();
				write_reg(PLAN[r].idx, PLAN[r].data);
			end else begin
				send_sample(PLAN[r].tgt, PLAN[r].meas, PLAN[r].typed, PLAN[r].want);
			end
		end

		// random phases, each under fresh settings; the last runs without idling
		for (int ph = 0; ph < NPHASE; ph++) begin
			drain();
			random_setup();
			calm = (ph == NPHASE - 1);
			case ($urandom_range(0, 3))
				0: src_pct = 0;
				1: src_pct = 10;
				2: src_pct = 30;
				default: src_pct = 60;
			endcase
			case ($urandom_range(0, 3))
				0: sink_pct = 0;
				1: sink_pct = 10;
				2: sink_pct = 30;
				default: sink_pct = 60;
			endcase
			repeat (PHASE_ITEMS) random_sample();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_drive.size() == 0)
			$display("pid_controller_clamped_top verification clean");
		else
			$display("pid_controller_clamped_top verification failed");
		$finish;
	end

endmodule

@@ pid_controller_clamped_top.f @@
rtl/core/pidc_pkg.sv
rtl/core/pidc_in_if.sv
rtl/core/pidc_out_if.sv
rtl/core/pidc_div.sv
rtl/core/pid_controller_clamped_top.sv
test/pid_controller_clamped_top_tb.sv
